// ===== hdl/phase_offset_running_stats_unit_defines.svh =====
// Assertion macros used by the RTL in posru_datapath.
`ifndef PHASE_OFFSET_RUNNING_STATS_UNIT_DEFINES_SVH
`define PHASE_OFFSET_RUNNING_STATS_UNIT_DEFINES_SVH

// Checked at every rising edge outside reset.
`define POSRU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define POSRU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/posru_pkg.sv =====
package posru_pkg;

  localparam logic [63:0] NS_TO_AS = 64'd1000000000;
  localparam logic [63:0] NS2_TO_AS = 64'd2000000000;
  // floor(2^62 / 10^9), used to estimate a quotient by the nanosecond scale.
  localparam logic [32:0] NS_RECIP = 33'd4611686018;
  localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32 = 32'sh80000000;
  localparam logic [31:0] CNT_MAX = 32'hffffffff;
  localparam logic [63:0] SUMSQ_MAX = 64'hffffffffffffffff;
  localparam logic [7:0] MODE_MIN = 8'd2;
  localparam logic KIND_CLEAR = 1'b0;
  localparam int DIV_W = 64;

  typedef struct packed {
    logic signed [31:0] mn;
    logic signed [31:0] mx;
    logic signed [47:0] mean;
    logic [63:0] sumsq;
  } chan_t;

  typedef struct packed {
    logic [31:0] cnt;
    chan_t m;
    chan_t p;
  } entry_t;

  localparam chan_t CHAN_RESET = '{mn: MAX32, mx: MIN32, mean: 48'sd0, sumsq: 64'd0};
  localparam entry_t ENTRY_RESET = '{cnt: 32'd0, m: CHAN_RESET, p: CHAN_RESET};

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_FOLD, ST_FMOD, ST_FQUO, ST_STAT, ST_MEAN,
    ST_MUL, ST_VAR, ST_SQRT, ST_NEXT, ST_WRITE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_READ, OP_FOLD, OP_FMOD, OP_FQUO,
    OP_STAT, OP_MEAN, OP_MUL, OP_VAR, OP_SQRT, OP_NEXT, OP_WRITE
  } op_t;

  typedef struct packed {
    logic sid_ok;
    logic per_zero;
    logic first;
    logic last_ch;
    logic div_done;
    logic mul_done;
    logic sqrt_done;
    logic quo_done;
  } status_t;

endpackage

// ===== hdl/posru_ram.sv =====
module posru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/posru_div.sv =====
module posru_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [posru_pkg::DIV_W-1:0] dividend,
  input  logic [posru_pkg::DIV_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [posru_pkg::DIV_W-1:0] quot,
  output logic [posru_pkg::DIV_W-1:0] rem
);
  import posru_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_r, rem_r, den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DIV_W:0]   sh;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  assign sh = {rem_r, quo_r[DIV_W-1]};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? DIV_W'(sh - {1'b0, den_r}) : sh[DIV_W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;
endmodule

// ===== hdl/posru_sqrt.sv =====
module posru_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [47:0] root
);
  // Square root of value * 2^24, two radicand bits per cycle.
  localparam int STEPS = 44;

  logic [87:0] rad_r;
  logic [45:0] rem_r;
  logic [43:0] root_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [47:0] rem_sh, trial;
  logic        ge;

  assign rem_sh = {rem_r, rad_r[87:86]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {value, 24'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[85:0], 2'b00};
      rem_r  <= ge ? 46'(rem_sh - trial) : rem_sh[45:0];
      root_r <= {root_r[42:0], ge};
    end
  end

  assign done = done_r;
  assign root = {4'd0, root_r};
endmodule

// ===== hdl/posru_ctrl.sv =====
module posru_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_kind,
  input  logic               in_set_valid,
  input  logic [7:0]         in_mode,
  input  posru_pkg::status_t status,
  output posru_pkg::op_t     op,
  output logic               busy
);
  import posru_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start && status.sid_ok) begin
          if (in_kind == KIND_CLEAR) begin
            op = OP_CLEAR;
          end else if (in_set_valid && in_mode >= MODE_MIN) begin
            op        = OP_LOAD;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        op        = OP_READ;
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        op        = OP_FOLD;
        state_nxt = status.per_zero ? ST_STAT : ST_FMOD;
      end
      ST_FMOD: begin
        op = OP_FMOD;
        if (status.div_done) state_nxt = ST_FQUO;
      end
      ST_FQUO: begin
        op = OP_FQUO;
        if (status.quo_done) state_nxt = ST_STAT;
      end
      ST_STAT: begin
        op        = OP_STAT;
        state_nxt = status.first ? ST_NEXT : ST_MEAN;
      end
      ST_MEAN: begin
        op = OP_MEAN;
        if (status.div_done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        op = OP_MUL;
        if (status.mul_done) state_nxt = ST_VAR;
      end
      ST_VAR: begin
        op = OP_VAR;
        if (status.div_done) state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        op = OP_SQRT;
        if (status.sqrt_done) state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        op        = OP_NEXT;
        state_nxt = status.last_ch ? ST_WRITE : ST_FOLD;
      end
      ST_WRITE: begin
        op        = OP_WRITE;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);
endmodule

// ===== hdl/posru_datapath.sv =====
`include "phase_offset_running_stats_unit_defines.svh"
module posru_datapath #(
  parameter int NUM_SEQUENCES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  posru_pkg::op_t      op,
  output posru_pkg::status_t  status,
  input  logic [3:0]          in_sid,
  input  logic signed [31:0]  in_trig_correction,
  input  logic [62:0]         in_h1_period,
  input  logic signed [31:0]  in_match_stamp,
  input  logic signed [31:0]  in_phase_stamp,
  output logic                out_valid,
  output logic [3:0]          out_sid,
  output logic [31:0]         out_sample_count,
  output logic signed [31:0]  out_match_act,
  output logic signed [47:0]  out_match_mean,
  output logic [47:0]         out_match_sdev,
  output logic signed [31:0]  out_match_min,
  output logic signed [31:0]  out_match_max,
  output logic signed [31:0]  out_phase_act,
  output logic signed [47:0]  out_phase_mean,
  output logic [47:0]         out_phase_sdev,
  output logic signed [31:0]  out_phase_min,
  output logic signed [31:0]  out_phase_max
);
  import posru_pkg::*;

  localparam int AW = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int EW = $bits(entry_t);

  logic [NUM_SEQUENCES-1:0] valid_r;
  logic                     hit_r, out_valid_r, ch_r;
  logic [3:0]               sid_r;
  logic [62:0]              per_r;
  logic signed [32:0]       xm_r, xp_r, x_r;
  logic [31:0]              cnt_r;
  chan_t                    w_r, p_r, m_r;
  logic signed [31:0]       w_act_r, m_act_r;
  logic [47:0]              w_sdev_r, m_sdev_r;
  logic                     qneg_r;
  logic signed [48:0]       d_r;

  logic [97:0] acc_r;
  logic [48:0] mcand_r;
  logic [5:0]  mcnt_r;
  logic        mbusy_r, mul_done_r;

  logic [63:0] vq_r, qrem_r;
  logic [32:0] q0_r, qfin_r;
  logic        qs1_r, qs2_r, qs3_r, quo_done_r;
  logic [64:0] qprod;
  logic [1:0]  qcorr;

  logic [AW-1:0]   in_addr, sid_addr;
  logic [EW-1:0]   ram_rd;
  entry_t          ram_ent, ent;
  logic            ram_we;

  logic            div_start, div_busy, div_done;
  logic [63:0]     div_a, div_b, div_quot, div_rem;
  logic            sqrt_start, sqrt_done;
  logic [47:0]     sqrt_root;

  logic               x_neg;
  logic [32:0]        x_abs;
  logic [63:0]        a_prod;
  logic signed [31:0] act_x, act_q;
  logic               r_gt;
  logic [63:0]        vmag;
  logic signed [47:0] val;
  logic signed [48:0] d_c, e_c;
  logic signed [49:0] dq, m_full;
  logic signed [47:0] m_c;
  logic [49:0]        mul_sum;
  logic [63:0]        inc;
  logic [64:0]        sum65;
  logic [63:0]        sumsq_c;

  function automatic logic [48:0] abs49(input logic signed [48:0] v);
    abs49 = v[48] ? 49'(-v) : 49'(v);
  endfunction

  assign in_addr  = AW'(in_sid);
  assign sid_addr = AW'(sid_r);
  assign ram_ent  = ram_rd;
  assign ent      = hit_r ? ram_ent : ENTRY_RESET;
  assign ram_we   = (op == OP_WRITE);

  // Fold the timestamp to the nearest edge of the period.
  assign x_neg  = x_r[32];
  assign x_abs  = x_neg ? 33'(-x_r) : 33'(x_r);
  assign a_prod = {31'd0, x_abs} * NS_TO_AS;
  assign act_x  = (x_r > 33'sd2147483647) ? MAX32 :
                  (x_r < -33'sd2147483648) ? MIN32 : x_r[31:0];
  assign r_gt   = div_rem > {2'b00, per_r[62:1]};
  assign vmag   = r_gt ? ({1'b0, per_r} - div_rem) : div_rem;

  // The magnitude is below 2^62, so the reciprocal estimate is low by at most two;
  // the remainder then settles the last step.
  assign qprod  = {33'd0, vq_r[61:30]} * {32'd0, NS_RECIP};
  assign qcorr  = (qrem_r >= NS2_TO_AS) ? 2'd2 : ((qrem_r >= NS_TO_AS) ? 2'd1 : 2'd0);
  assign act_q  = !qneg_r ? ((|qfin_r[32:31]) ? MAX32 : {1'b0, qfin_r[30:0]}) :
                  ((qfin_r > 33'd2147483648) ? MIN32 : -qfin_r[31:0]);

  // Welford update.
  assign val    = {w_act_r, 16'd0};
  assign d_c    = 49'(val) - 49'(w_r.mean);
  assign dq     = d_r[48] ? -$signed({1'b0, div_quot[48:0]}) : $signed({1'b0, div_quot[48:0]});
  assign m_full = 50'(w_r.mean) + dq;
  assign m_c    = m_full[47:0];
  assign e_c    = 49'(val) - 49'(m_c);

  assign mul_sum = {1'b0, acc_r[97:49]} + (acc_r[0] ? {1'b0, mcand_r} : 50'd0);
  assign inc     = (|acc_r[97:88]) ? SUMSQ_MAX : acc_r[87:24];
  assign sum65   = {1'b0, w_r.sumsq} + {1'b0, inc};
  assign sumsq_c = sum65[64] ? SUMSQ_MAX : sum65[63:0];

  always_comb begin
    div_start = 1'b0;
    div_a     = a_prod;
    div_b     = {1'b0, per_r};
    case (op)
      OP_FOLD: begin
        div_start = (per_r != 63'd0);
      end
      OP_STAT: begin
        div_start = (cnt_r != 32'd1);
        div_a     = {15'd0, abs49(d_c)};
        div_b     = {32'd0, cnt_r};
      end
      OP_MUL: begin
        div_start = mul_done_r;
        div_a     = sumsq_c;
        div_b     = {32'd0, cnt_r - 32'd1};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start = (op == OP_VAR) && div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      mbusy_r     <= 1'b0;
      mul_done_r  <= 1'b0;
      mcnt_r      <= '0;
      ch_r        <= 1'b0;
      qs1_r       <= 1'b0;
      qs2_r       <= 1'b0;
      qs3_r       <= 1'b0;
      quo_done_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      mul_done_r  <= 1'b0;
      qs1_r       <= (op == OP_FMOD) && div_done;
      qs2_r       <= qs1_r;
      qs3_r       <= qs2_r;
      quo_done_r  <= qs3_r;
      if (op == OP_CLEAR) valid_r[in_addr] <= 1'b0;
      if (op == OP_WRITE) begin
        valid_r[sid_addr] <= 1'b1;
        out_valid_r       <= 1'b1;
      end
      if (op == OP_READ) ch_r <= 1'b0;
      if (op == OP_NEXT) ch_r <= 1'b1;
      if (op == OP_MEAN && div_done) begin
        mbusy_r <= 1'b1;
        mcnt_r  <= '0;
      end else if (mbusy_r) begin
        mcnt_r <= mcnt_r + 1'b1;
        if (mcnt_r == 6'd48) begin
          mbusy_r    <= 1'b0;
          mul_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        sid_r <= in_sid;
        per_r <= in_h1_period;
        xm_r  <= 33'(in_match_stamp) - 33'(in_trig_correction);
        xp_r  <= 33'(in_phase_stamp);
        hit_r <= valid_r[in_addr];
      end
      OP_READ: begin
        cnt_r <= (ent.cnt == CNT_MAX) ? CNT_MAX : ent.cnt + 32'd1;
        w_r   <= ent.m;
        p_r   <= ent.p;
        x_r   <= xm_r;
      end
      OP_FOLD: begin
        if (per_r == 63'd0) w_act_r <= act_x;
      end
      OP_FMOD: begin
        if (div_done) begin
          qneg_r <= x_neg ^ r_gt;
          vq_r   <= vmag;
        end
      end
      OP_FQUO: begin
        if (quo_done_r) w_act_r <= act_q;
      end
      OP_STAT: begin
        d_r <= d_c;
        if (w_act_r < w_r.mn) w_r.mn <= w_act_r;
        if (w_act_r > w_r.mx) w_r.mx <= w_act_r;
        if (cnt_r == 32'd1) begin
          w_r.mean  <= val;
          w_r.sumsq <= 64'd0;
          w_sdev_r  <= 48'd0;
        end
      end
      OP_MEAN: begin
        if (div_done) w_r.mean <= m_c;
      end
      OP_MUL: begin
        if (mul_done_r) w_r.sumsq <= sumsq_c;
      end
      OP_SQRT: begin
        if (sqrt_done) w_sdev_r <= sqrt_root;
      end
      OP_NEXT: begin
        if (!ch_r) begin
          m_r      <= w_r;
          m_act_r  <= w_act_r;
          m_sdev_r <= w_sdev_r;
          w_r      <= p_r;
          x_r      <= xp_r;
        end
      end
      default: begin
      end
    endcase
    if (qs1_r) q0_r <= qprod[64:32];
    if (qs2_r) qrem_r <= vq_r - {31'd0, q0_r} * NS_TO_AS;
    if (qs3_r) qfin_r <= q0_r + {31'd0, qcorr};
    // Shift-add multiplier for |d| * |e|, one multiplier bit per cycle.
    if (op == OP_MEAN && div_done) begin
      mcand_r <= abs49(d_r);
      acc_r   <= {49'd0, abs49(e_c)};
    end else if (mbusy_r) begin
      acc_r <= {mul_sum, acc_r[48:1]};
    end
  end

  posru_ram #(.WIDTH(EW), .DEPTH(NUM_SEQUENCES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sid_addr),
    .wdata ({cnt_r, m_r, w_r}),
    .raddr (in_addr),
    .rdata (ram_rd)
  );

  posru_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  posru_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (div_quot),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign status.sid_ok    = ({28'd0, in_sid} < 32'(NUM_SEQUENCES));
  assign status.per_zero  = (per_r == 63'd0);
  assign status.first     = (cnt_r == 32'd1);
  assign status.last_ch   = ch_r;
  assign status.div_done  = div_done;
  assign status.mul_done  = mul_done_r;
  assign status.sqrt_done = sqrt_done;
  assign status.quo_done  = quo_done_r;

  assign out_valid        = out_valid_r;
  assign out_sid          = sid_r;
  assign out_sample_count = cnt_r;
  assign out_match_act    = m_act_r;
  assign out_match_mean   = m_r.mean;
  assign out_match_sdev   = m_sdev_r;
  assign out_match_min    = m_r.mn;
  assign out_match_max    = m_r.mx;
  assign out_phase_act    = w_act_r;
  assign out_phase_mean   = w_r.mean;
  assign out_phase_sdev   = w_sdev_r;
  assign out_phase_min    = w_r.mn;
  assign out_phase_max    = w_r.mx;

  `POSRU_ASSERT(a_div_not_restarted, clk, rst_n, div_start |-> !div_busy, "divider restarted mid-run")
  `POSRU_ASSERT(a_units_exclusive, clk, rst_n, !(div_done && mul_done_r), "two units finished together")
  `POSRU_ASSERT(a_single_strobe, clk, rst_n, out_valid_r |=> !out_valid_r, "result strobe held")
  `POSRU_ASSERT(a_sqrt_alone, clk, rst_n, sqrt_start |-> !div_start, "root and divide started together")
endmodule

// ===== hdl/phase_offset_running_stats_unit.sv =====
// Channel   | Handshake              | Payload
// input     | start, busy            | in_kind, in_sid, in_set_valid, in_mode, in_trig_correction,
//           |                        | in_h1_period, in_match_stamp, in_phase_stamp
// result    | out_valid (one cycle)  | out_sid, out_sample_count, out_match_*, out_phase_*
//
// Per channel a sample passes through up to three runs of the shared divider, a reciprocal
// division by 10^9, a multiplier and a square root before its result strobe.
// A zero period skips the folding divisions; the first sample after a clear skips the rest.
// A clear transaction or an ignored one is taken without leaving idle and busy stays low.
// Reset is synchronous and marks every id as cleared; no clearing pass is needed.
// The receiver cannot stall: each result is flagged by out_valid for exactly one cycle.
module phase_offset_running_stats_unit #(
  parameter int NUM_SEQUENCES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [3:0]         in_sid,
  input  logic               in_set_valid,
  input  logic [7:0]         in_mode,
  input  logic signed [31:0] in_trig_correction,
  input  logic [62:0]        in_h1_period,
  input  logic signed [31:0] in_match_stamp,
  input  logic signed [31:0] in_phase_stamp,
  output logic               out_valid,
  output logic [3:0]         out_sid,
  output logic [31:0]        out_sample_count,
  output logic signed [31:0] out_match_act,
  output logic signed [47:0] out_match_mean,
  output logic [47:0]        out_match_sdev,
  output logic signed [31:0] out_match_min,
  output logic signed [31:0] out_match_max,
  output logic signed [31:0] out_phase_act,
  output logic signed [47:0] out_phase_mean,
  output logic [47:0]        out_phase_sdev,
  output logic signed [31:0] out_phase_min,
  output logic signed [31:0] out_phase_max
);
  import posru_pkg::*;

  op_t     op;
  status_t status;

  posru_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_kind      (in_kind),
    .in_set_valid (in_set_valid),
    .in_mode      (in_mode),
    .status       (status),
    .op           (op),
    .busy         (busy)
  );

  posru_datapath #(.NUM_SEQUENCES(NUM_SEQUENCES)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .status             (status),
    .in_sid             (in_sid),
    .in_trig_correction (in_trig_correction),
    .in_h1_period       (in_h1_period),
    .in_match_stamp     (in_match_stamp),
    .in_phase_stamp     (in_phase_stamp),
    .out_valid          (out_valid),
    .out_sid            (out_sid),
    .out_sample_count   (out_sample_count),
    .out_match_act      (out_match_act),
    .out_match_mean     (out_match_mean),
    .out_match_sdev     (out_match_sdev),
    .out_match_min      (out_match_min),
    .out_match_max      (out_match_max),
    .out_phase_act      (out_phase_act),
    .out_phase_mean     (out_phase_mean),
    .out_phase_sdev     (out_phase_sdev),
    .out_phase_min      (out_phase_min),
    .out_phase_max      (out_phase_max)
  );
endmodule
